// ===== rtl/range_sum_segment_tree_top_defines.svh =====
// ----------------------------------------------------------------------------
// Range sum segment tree assertion macros
// Shared shorthand for the concurrent checks on the top level ports.
// ----------------------------------------------------------------------------
`ifndef RANGE_SUM_SEGMENT_TREE_TOP_DEFINES_SVH
`define RANGE_SUM_SEGMENT_TREE_TOP_DEFINES_SVH

// Check that is switched off while reset is high.
`define RSST_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Check that also runs through reset.
`define RSST_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

// ===== rtl/rsst_pkg.sv =====
// ----------------------------------------------------------------------------
// Range sum segment tree package
// Field widths, request codes and the command and status bundles between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package rsst_pkg;

   localparam int VALUE_W = 32;
   localparam int POS_W   = 10;
   localparam int BOUND_W = 11;

   localparam logic REQ_UPDATE = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;

   typedef struct packed {
      logic clr_write;
      logic upd_load;
      logic upd_leaf;
      logic upd_climb;
      logic qry_load;
      logic qry_step;
   } dp_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic pos_ok;
      logic root;
      logic qry_live;
   } dp_status_type;

endpackage

// ===== rtl/rsst_dp.sv =====
// ----------------------------------------------------------------------------
// Range sum segment tree datapath
// Node store with one write port and two registered read ports, the update
// climb registers, the query bound registers and the two accumulators.
// ----------------------------------------------------------------------------
module rsst_dp
   import rsst_pkg::*;
#(
   parameter int LEAVES = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dp_cmd_type                cmd,
   output dp_status_type             status,
   input  logic [POS_W-1:0]          req_position,
   input  logic [VALUE_W-1:0]        req_new_value,
   input  logic [BOUND_W-1:0]        req_range_left,
   input  logic [BOUND_W-1:0]        req_range_right,
   output logic [VALUE_W-1:0]        range_total
);

   localparam int NODES  = 2 * LEAVES;
   localparam int NODE_W = $clog2(NODES);
   localparam int IDX_W  = NODE_W + 1;
   localparam int EXT_W  = ((IDX_W > BOUND_W) ? IDX_W : BOUND_W) + 1;

   logic [VALUE_W-1:0] mem [NODES];

   logic [NODE_W-1:0]  clr_addr_ff;
   logic [NODE_W-1:0]  node_ff;
   logic [VALUE_W-1:0] val_ff;
   logic [IDX_W-1:0]   lo_ff;
   logic [IDX_W-1:0]   hi_ff;
   logic               take_l_ff;
   logic               take_r_ff;
   logic [VALUE_W-1:0] acc_l_ff;
   logic [VALUE_W-1:0] acc_r_ff;
   logic [VALUE_W-1:0] rd_a_ff;
   logic [VALUE_W-1:0] rd_b_ff;

   logic               wr_en;
   logic [NODE_W-1:0]  wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic [NODE_W-1:0]  rd_a_addr;
   logic [NODE_W-1:0]  rd_b_addr;
   logic [VALUE_W-1:0] sum_val;
   logic [EXT_W-1:0]   left_ext;
   logic [EXT_W-1:0]   right_ext;
   logic [EXT_W-1:0]   left_clamp;
   logic [EXT_W-1:0]   right_clamp;
   logic [IDX_W-1:0]   lo_start;
   logic [IDX_W-1:0]   hi_start;
   logic [NODE_W-1:0]  leaf_node;

   // Bounds above the leaf count are clamped, then moved to the leaf row.
   always_comb begin
      left_ext    = EXT_W'(req_range_left);
      right_ext   = EXT_W'(req_range_right);
      left_clamp  = (left_ext > EXT_W'(LEAVES)) ? EXT_W'(LEAVES) : left_ext;
      right_clamp = (right_ext > EXT_W'(LEAVES)) ? EXT_W'(LEAVES) : right_ext;
      lo_start    = IDX_W'(left_clamp) + IDX_W'(LEAVES);
      hi_start    = IDX_W'(right_clamp) + IDX_W'(LEAVES);
      leaf_node   = NODE_W'(req_position) + NODE_W'(LEAVES);
   end

   assign sum_val = val_ff + rd_a_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = node_ff;
      wr_data = val_ff;
      if (cmd.clr_write) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else if (cmd.upd_leaf) begin
         wr_en = 1'b1;
      end else if (cmd.upd_climb) begin
         wr_en   = 1'b1;
         wr_data = sum_val;
      end
   end

   // During an update port A fetches the sibling of the node being written.
   assign rd_a_addr = cmd.qry_step ? NODE_W'(lo_ff) : (node_ff ^ NODE_W'(1));
   assign rd_b_addr = NODE_W'(hi_ff - IDX_W'(1));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         take_l_ff   <= 1'b0;
         take_r_ff   <= 1'b0;
      end else begin
         if (cmd.clr_write) begin
            clr_addr_ff <= clr_addr_ff + NODE_W'(1);
         end
         if (cmd.qry_load) begin
            take_l_ff <= 1'b0;
            take_r_ff <= 1'b0;
         end else if (cmd.qry_step) begin
            take_l_ff <= status.qry_live & lo_ff[0];
            take_r_ff <= status.qry_live & hi_ff[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.upd_load) begin
         node_ff <= leaf_node;
         val_ff  <= req_new_value;
      end else if (cmd.upd_leaf) begin
         node_ff <= node_ff >> 1;
      end else if (cmd.upd_climb) begin
         node_ff <= node_ff >> 1;
         val_ff  <= sum_val;
      end

      if (cmd.qry_load) begin
         lo_ff    <= lo_start;
         hi_ff    <= hi_start;
         acc_l_ff <= '0;
         acc_r_ff <= '0;
      end else if (cmd.qry_step) begin
         // Data read in the previous step is added here, one level behind.
         if (take_l_ff) begin
            acc_l_ff <= acc_l_ff + rd_a_ff;
         end
         if (take_r_ff) begin
            acc_r_ff <= acc_r_ff + rd_b_ff;
         end
         if (status.qry_live) begin
            lo_ff <= (lo_ff + IDX_W'(lo_ff[0])) >> 1;
            hi_ff <= hi_ff >> 1;
         end
      end
   end

   always_comb begin
      status.clr_last = (clr_addr_ff == NODE_W'(NODES - 1));
      status.pos_ok   = (EXT_W'(req_position) < EXT_W'(LEAVES));
      status.root     = (node_ff == NODE_W'(1));
      status.qry_live = (lo_ff < hi_ff);
   end

   assign range_total = acc_l_ff + acc_r_ff;

endmodule

// ===== rtl/rsst_ctrl.sv =====
// ----------------------------------------------------------------------------
// Range sum segment tree controller
// Sequences the clearing pass, the update climb and the query walk, and
// drives busy and the result strobe.
// ----------------------------------------------------------------------------
module rsst_ctrl
   import rsst_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          req_type,
   input  dp_status_type status,
   output dp_cmd_type    cmd,
   output logic          busy,
   output logic          rsp_valid
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPD_LEAF,
      ST_UPD_CLIMB,
      ST_QUERY,
      ST_RESP
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      busy_ff;
   logic      busy_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               if (req_type == REQ_QUERY) begin
                  cmd.qry_load = 1'b1;
                  state_in     = ST_QUERY;
               end else if (status.pos_ok) begin
                  cmd.upd_load = 1'b1;
                  state_in     = ST_UPD_LEAF;
               end
            end
         end
         ST_UPD_LEAF: begin
            cmd.upd_leaf = 1'b1;
            state_in     = ST_UPD_CLIMB;
         end
         ST_UPD_CLIMB: begin
            cmd.upd_climb = 1'b1;
            if (status.root) begin
               state_in = ST_IDLE;
            end
         end
         ST_QUERY: begin
            cmd.qry_step = 1'b1;
            if (!status.qry_live) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      busy_in      = (state_in != ST_IDLE);
      rsp_valid_in = (state_in == ST_RESP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         busy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/range_sum_segment_tree_top.sv =====
// ----------------------------------------------------------------------------
// Range sum segment tree
// Point update and half-open range sum over LEAVES 32-bit leaves.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. req_type selects a
// point update (req_position, req_new_value) or a range sum query over
// [req_range_left, req_range_right); bounds above LEAVES are clamped and an
// empty or reversed range sums to zero. Sums wrap at 32 bits.
// An update gives no result; one whose position is not below LEAVES is
// dropped and busy stays low. A valid update holds busy for one store
// write per tree level, each level's sibling read overlapping the write
// below it.
// A query holds busy for its level steps on the two store read ports, one
// step that adds the last reads, and the cycle that presents
// rsp_range_total with rsp_valid. An empty range has no level steps before
// the adding step. The receiver cannot hold it off.
// After reset the node store is cleared one entry per cycle, all 2 * LEAVES
// entries with busy high, before the first request is taken.
// ----------------------------------------------------------------------------
module range_sum_segment_tree_top
   import rsst_pkg::*;
#(
   parameter int LEAVES = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_type,
   input  logic [POS_W-1:0]          req_position,
   input  logic signed [VALUE_W-1:0] req_new_value,
   input  logic [BOUND_W-1:0]        req_range_left,
   input  logic [BOUND_W-1:0]        req_range_right,
   output logic                      rsp_valid,
   output logic signed [VALUE_W-1:0] rsp_range_total
);

   dp_cmd_type         cmd;
   dp_status_type      status;
   logic [VALUE_W-1:0] range_total;

   rsst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_type  (req_type),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   rsst_dp #(
      .LEAVES (LEAVES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_position    (req_position),
      .req_new_value   (req_new_value),
      .req_range_left  (req_range_left),
      .req_range_right (req_range_right),
      .range_total     (range_total)
   );

   assign rsp_range_total = range_total;

endmodule

// ===== rtl/rsst_checker.sv =====
// ----------------------------------------------------------------------------
// Range sum segment tree port checker
// Concurrent checks on the top level handshake, bound to the top level.
// ----------------------------------------------------------------------------
`include "range_sum_segment_tree_top_defines.svh"

module rsst_checker
   import rsst_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_type,
   input logic rsp_valid
);

   // A result strobe lasts one cycle.
   `RSST_ASSERT(a_strobe_single, rsp_valid |=> !rsp_valid, "result strobe held too long")

   // A result is shown while the query still owns the block.
   `RSST_ASSERT(a_strobe_busy, rsp_valid |-> busy, "result shown while idle")

   // A taken query keeps the block busy until its result.
   `RSST_ASSERT(a_query_busy, start && !busy && req_type == REQ_QUERY |=> busy, "query not held")

   // An update request never produces a result right after it is taken.
   `RSST_ASSERT(a_update_silent, start && !busy && req_type == REQ_UPDATE |=> !rsp_valid, "update gave a result")

   // Reset starts the clearing pass with no result pending.
   `RSST_ASSERT_RST(a_reset_clear, reset |=> busy && !rsp_valid, "reset did not start clearing")

endmodule

bind range_sum_segment_tree_top rsst_checker u_checker (.*);

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// Range sum segment tree testbench
// Drives point updates and range sum queries through the start/busy port,
// keeps its own copy of the node store to predict every query total, and
// checks each strobed total against the oldest prediction in order.
// ----------------------------------------------------------------------------
module tb
   import rsst_pkg::*;
();

   localparam int LEAVES         = 1024;
   localparam int NODE_W         = $clog2(2 * LEAVES);
   localparam int IDX_W          = NODE_W + 1;
   localparam int TIMEOUT_CYCLES = 400000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int MAX_REPORTS    = 10;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic                      req_type;
   logic [POS_W-1:0]          req_position;
   logic signed [VALUE_W-1:0] req_new_value;
   logic [BOUND_W-1:0]        req_range_left;
   logic [BOUND_W-1:0]        req_range_right;
   logic                      rsp_valid;
   logic signed [VALUE_W-1:0] rsp_range_total;

   // Predicted node store: node LEAVES+i is leaf i, node k sums nodes 2k and 2k+1.
   logic [VALUE_W-1:0] node_sums [0:2*LEAVES-1];
   logic [VALUE_W-1:0] pending_totals [$];
   int                 fail_count;
   int                 idle_pct;

   range_sum_segment_tree_top #(.LEAVES(LEAVES)) DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_position    (req_position),
      .req_new_value   (req_new_value),
      .req_range_left  (req_range_left),
      .req_range_right (req_range_right),
      .rsp_valid       (rsp_valid),
      .rsp_range_total (rsp_range_total)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_CYCLES * 10);
      $display("Simulation FAILED");
      $finish;
   end

   function automatic void store_leaf(input logic [POS_W-1:0] pos,
                                      input logic [VALUE_W-1:0] value);
      logic [NODE_W-1:0] node;
      if (pos >= LEAVES) return;
      node = NODE_W'(pos) + NODE_W'(LEAVES);
      node_sums[node] = value;
      node = node >> 1;
      while (node != 0) begin
         node_sums[node] = node_sums[{node[NODE_W-2:0], 1'b0}]
                         + node_sums[{node[NODE_W-2:0], 1'b1}];
         node = node >> 1;
      end
   endfunction

   function automatic logic [VALUE_W-1:0] sum_range(input logic [BOUND_W-1:0] left,
                                                   input logic [BOUND_W-1:0] right);
      logic [IDX_W-1:0]   lo;
      logic [IDX_W-1:0]   hi;
      logic [VALUE_W-1:0] acc_left;
      logic [VALUE_W-1:0] acc_right;
      lo = (left > LEAVES) ? IDX_W'(LEAVES) : IDX_W'(left);
      hi = (right > LEAVES) ? IDX_W'(LEAVES) : IDX_W'(right);
      lo = lo + IDX_W'(LEAVES);
      hi = hi + IDX_W'(LEAVES);
      acc_left  = '0;
      acc_right = '0;
      while (lo < hi) begin
         if (lo[0]) begin
            acc_left = acc_left + node_sums[lo[NODE_W-1:0]];
            lo++;
         end
         if (hi[0]) begin
            hi--;
            acc_right = acc_right + node_sums[hi[NODE_W-1:0]];
         end
         lo = lo >> 1;
         hi = hi >> 1;
      end
      return acc_left + acc_right;
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 80) return $urandom;
      case ($urandom_range(4))
         0: return 32'h0000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'hFFFF_FFFF;
         default: return 32'h0000_0001;
      endcase
   endfunction

   function automatic logic [BOUND_W-1:0] pick_bound();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 80) return BOUND_W'($urandom_range(LEAVES));
      if (sel < 88) return BOUND_W'($urandom_range(3));
      if (sel < 95) return BOUND_W'($urandom_range(LEAVES, LEAVES - 3));
      return BOUND_W'($urandom_range(2**BOUND_W - 1, LEAVES + 1));
   endfunction

   // The request is taken at the first edge that sees start high and busy low.
   // Each idle cycle is spent where the block could have taken the request.
   task automatic send_request(input logic kind, input logic [POS_W-1:0] pos,
                               input logic [VALUE_W-1:0] value,
                               input logic [BOUND_W-1:0] left,
                               input logic [BOUND_W-1:0] right);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while (busy);
      end
      start           <= 1'b1;
      req_type        <= kind;
      req_position    <= pos;
      req_new_value   <= value;
      req_range_left  <= left;
      req_range_right <= right;
      do @(posedge clock); while (busy);
      if (kind == REQ_UPDATE) store_leaf(pos, value);
      else pending_totals.push_back(sum_range(left, right));
   endtask

   task automatic send_update(input int unsigned pos, input logic [VALUE_W-1:0] value);
      send_request(REQ_UPDATE, POS_W'(pos), value, BOUND_W'($urandom), BOUND_W'($urandom));
   endtask

   task automatic send_query(input int unsigned left, input int unsigned right);
      send_request(REQ_QUERY, POS_W'($urandom), $urandom, BOUND_W'(left), BOUND_W'(right));
   endtask

   task automatic send_random_request();
      logic [POS_W-1:0] pos;
      // Half of the updates land in a small window so queries see overlapping writes.
      pos = ($urandom_range(1)) ? POS_W'($urandom) : POS_W'($urandom_range(15));
      if ($urandom_range(99) < 45) send_update(pos, pick_value());
      else send_query(pick_bound(), pick_bound());
   endtask

   task automatic wait_for_totals();
      start <= 1'b0;
      do @(posedge clock); while (pending_totals.size() != 0);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_totals.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("Unexpected range total %0d (%h)", rsp_range_total, rsp_range_total);
         end else begin
            logic [VALUE_W-1:0] expected_total;
            expected_total = pending_totals.pop_front();
            if (rsp_range_total !== expected_total) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("Range total mismatch: expected %0d (%h), got %0d (%h)",
                           $signed(expected_total), expected_total,
                           rsp_range_total, rsp_range_total);
            end
         end
      end
   end

   task automatic test_directed();
      send_query(0, LEAVES);
      send_update(0, 32'h7FFF_FFFF);
      send_update(LEAVES - 1, 32'h8000_0000);
      send_update(LEAVES / 2, 32'hFFFF_FFFF);
      send_update(1, 32'h7FFF_FFFF);
      send_query(0, LEAVES);
      send_query(0, 1);
      send_query(0, 2);
      send_query(LEAVES - 1, LEAVES);
      send_query(5, 5);
      send_query(10, 3);
      send_query(LEAVES, LEAVES);
      // Bounds past the last leaf are clamped to LEAVES.
      send_query(0, 2**BOUND_W - 1);
      send_query(2**BOUND_W - 1, 2**BOUND_W - 1);
      send_query(2**BOUND_W - 1, 0);
      send_query(LEAVES / 2, LEAVES + 7);
      send_request(REQ_QUERY, '1, '1, BOUND_W'(1), BOUND_W'(LEAVES - 1));
      send_request(REQ_UPDATE, POS_W'(2), 32'h0000_0005, '1, '1);
      send_update(0, 32'h0000_0000);
      send_query(0, 3);
      send_query(LEAVES / 2, LEAVES / 2 + 1);
   endtask

   task automatic test_random_mix();
      repeat (400) send_random_request();
   endtask

   task automatic test_back_to_back();
      idle_pct = 0;
      repeat (200) send_random_request();
      idle_pct = 27;
   endtask

   task automatic test_drained_restart();
      repeat (6) begin
         wait_for_totals();
         repeat (50) send_random_request();
      end
   endtask

   initial begin
      reset           <= 1'b1;
      start           <= 1'b0;
      req_type        <= REQ_UPDATE;
      req_position    <= '0;
      req_new_value   <= '0;
      req_range_left  <= '0;
      req_range_right <= '0;
      fail_count = 0;
      idle_pct   = 27;
      node_sums  = '{default: '0};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_mix();
      test_back_to_back();
      test_drained_restart();

      start <= 1'b0;
      while (pending_totals.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      fail_count += pending_totals.size();
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rsst_pkg.sv
rtl/rsst_dp.sv
rtl/rsst_ctrl.sv
rtl/range_sum_segment_tree_top.sv
rtl/rsst_checker.sv
test/tb.sv
